@@ rtl/cau_pkg.sv @@
package cau_pkg;

	localparam int PART_WIDTH = 16;
	localparam int FRAC_BITS  = 8;
	localparam int PROD_W     = 2 * PART_WIDTH;
	localparam int MAG_W      = 2 * PART_WIDTH + 2;
	localparam int REM_W      = 3 * PART_WIDTH + 1;
	localparam int CMP_W      = MAG_W + FRAC_BITS + PART_WIDTH;
	localparam int DIV_STAGES = PART_WIDTH;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef struct packed {
		op_t                          op;
		logic signed [PART_WIDTH-1:0] a_real;
		logic signed [PART_WIDTH-1:0] a_imag;
		logic signed [PART_WIDTH-1:0] b_real;
		logic signed [PART_WIDTH-1:0] b_imag;
	} in_t;

	typedef struct packed {
		logic signed [PART_WIDTH-1:0] res_real;
		logic signed [PART_WIDTH-1:0] res_imag;
		logic                         div_zero;
		logic                         overflow;
	} out_t;

	typedef struct packed {
		logic                  big;
		logic                  neg;
		logic [MAG_W-1:0]      mag;
		logic [REM_W-1:0]      rem;
		logic [PART_WIDTH-1:0] quo;
	} lane_t;

	typedef struct packed {
		logic              is_div;
		logic              dz;
		logic [PROD_W-1:0] den;
		lane_t             re;
		lane_t             im;
	} pipe_t;

	typedef struct packed {
		logic [PART_WIDTH-1:0] bits;
		logic                  ovf;
	} part_t;

	function automatic part_t clamp_part(input logic neg, input logic [MAG_W-1:0] m);
		logic [MAG_W-1:0] half;
		part_t r;
		half = MAG_W'(1) << (PART_WIDTH - 1);
		r.ovf = 1'b0;
		if (neg) begin
			if (m > half) begin
				r.ovf = 1'b1;
				r.bits = half[PART_WIDTH-1:0];
			end else begin
				r.bits = PART_WIDTH'(MAG_W'(0) - m);
			end
		end else begin
			if (m > half - MAG_W'(1)) begin
				r.ovf = 1'b1;
				r.bits = PART_WIDTH'(half - MAG_W'(1));
			end else begin
				r.bits = m[PART_WIDTH-1:0];
			end
		end
		return r;
	endfunction

endpackage

@@ rtl/cau_div_stage.sv @@
module cau_div_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           valid_i,
	input  cau_pkg::pipe_t data_i,
	output logic           valid_o,
	output cau_pkg::pipe_t data_o
);
	import cau_pkg::*;

	logic [REM_W-1:0] dsh;
	pipe_t            nxt;
	logic             ge_re, ge_im;
	logic [REM_W-1:0] nr_re, nr_im;

	// one restoring step per lane, remainder shifts left each stage
	always_comb begin
		dsh = REM_W'(data_i.den) << (PART_WIDTH - 1);
		nxt = data_i;
		ge_re = data_i.re.rem >= dsh;
		ge_im = data_i.im.rem >= dsh;
		nr_re = ge_re ? data_i.re.rem - dsh : data_i.re.rem;
		nr_im = ge_im ? data_i.im.rem - dsh : data_i.im.rem;
		nxt.re.rem = nr_re << 1;
		nxt.im.rem = nr_im << 1;
		nxt.re.quo = {data_i.re.quo[PART_WIDTH-2:0], ge_re};
		nxt.im.quo = {data_i.im.quo[PART_WIDTH-2:0], ge_im};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else if (en) begin
			valid_o <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_o <= nxt;
		end
	end

endmodule

@@ rtl/complex_arithmetic_unit.sv @@
// the path from input beat to output beat runs through 4 front stages, 16 divider
// stages and 1 output register
// throughput: one beat per cycle for every operation; the divider is fully pipelined,
// one quotient bit per stage; a stalled output holds the whole pipeline
// reset: arst_n clears all valid bits asynchronously; data registers are not reset
module complex_arithmetic_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  cau_pkg::in_t   in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output cau_pkg::out_t  out_data
);
	import cau_pkg::*;

	logic adv;
	assign adv = !out_valid || out_ready;
	assign in_ready = adv;

	// stage 1: products and add/sub
	logic                         v_s1;
	op_t                          op_s1;
	logic signed [PROD_W-1:0]     rr_s1, ii_s1, ri_s1, ir_s1, sr_s1, si_s1;
	logic signed [PART_WIDTH:0]   asr_s1, asi_s1;
	logic                         bz_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1 <= in_data.op;
			rr_s1 <= PROD_W'(in_data.a_real) * PROD_W'(in_data.b_real);
			ii_s1 <= PROD_W'(in_data.a_imag) * PROD_W'(in_data.b_imag);
			ri_s1 <= PROD_W'(in_data.a_real) * PROD_W'(in_data.b_imag);
			ir_s1 <= PROD_W'(in_data.a_imag) * PROD_W'(in_data.b_real);
			sr_s1 <= PROD_W'(in_data.b_real) * PROD_W'(in_data.b_real);
			si_s1 <= PROD_W'(in_data.b_imag) * PROD_W'(in_data.b_imag);
			if (in_data.op == OP_SUB) begin
				asr_s1 <= (PART_WIDTH+1)'(in_data.a_real) - (PART_WIDTH+1)'(in_data.b_real);
				asi_s1 <= (PART_WIDTH+1)'(in_data.a_imag) - (PART_WIDTH+1)'(in_data.b_imag);
			end else begin
				asr_s1 <= (PART_WIDTH+1)'(in_data.a_real) + (PART_WIDTH+1)'(in_data.b_real);
				asi_s1 <= (PART_WIDTH+1)'(in_data.a_imag) + (PART_WIDTH+1)'(in_data.b_imag);
			end
			bz_s1 <= (in_data.b_real == '0) && (in_data.b_imag == '0);
		end
	end

	// stage 2: signed sums and divisor
	logic                     v_s2;
	op_t                      op_s2;
	logic                     dz_s2;
	logic signed [MAG_W-1:0]  sre_s2, sim_s2;
	logic [PROD_W-1:0]        den_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s2 <= op_s1;
			dz_s2 <= (op_s1 == OP_DIV) && bz_s1;
			den_s2 <= PROD_W'(unsigned'(sr_s1)) + PROD_W'(unsigned'(si_s1));
			case (op_s1)
				OP_MUL: begin
					sre_s2 <= MAG_W'(rr_s1) - MAG_W'(ii_s1);
					sim_s2 <= MAG_W'(ri_s1) + MAG_W'(ir_s1);
				end
				OP_DIV: begin
					sre_s2 <= MAG_W'(rr_s1) + MAG_W'(ii_s1);
					sim_s2 <= MAG_W'(ir_s1) - MAG_W'(ri_s1);
				end
				default: begin
					sre_s2 <= MAG_W'(asr_s1);
					sim_s2 <= MAG_W'(asi_s1);
				end
			endcase
		end
	end

	// stage 3: sign and magnitude, multiply magnitudes shifted down by FRAC_BITS
	logic               v_s3;
	op_t                op_s3;
	logic               dz_s3;
	logic [PROD_W-1:0]  den_s3;
	logic               nre_s3, nim_s3;
	logic [MAG_W-1:0]   mre_s3, mim_s3;
	logic [MAG_W-1:0]   abs_re, abs_im;

	always_comb begin
		abs_re = sre_s2[MAG_W-1] ? MAG_W'(0) - unsigned'(sre_s2) : unsigned'(sre_s2);
		abs_im = sim_s2[MAG_W-1] ? MAG_W'(0) - unsigned'(sim_s2) : unsigned'(sim_s2);
		if (op_s2 == OP_MUL) begin
			abs_re = abs_re >> FRAC_BITS;
			abs_im = abs_im >> FRAC_BITS;
		end
		if (dz_s2) begin
			abs_re = '0;
			abs_im = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s3 <= op_s2;
			dz_s3 <= dz_s2;
			den_s3 <= den_s2;
			nre_s3 <= sre_s2[MAG_W-1];
			nim_s3 <= sim_s2[MAG_W-1];
			mre_s3 <= abs_re;
			mim_s3 <= abs_im;
		end
	end

	// stage 4: quotient range check and divider setup
	logic             v_s4;
	pipe_t            p_s4;
	logic [CMP_W-1:0] num_re, num_im, dlim;

	always_comb begin
		num_re = CMP_W'(mre_s3) << FRAC_BITS;
		num_im = CMP_W'(mim_s3) << FRAC_BITS;
		dlim = CMP_W'(den_s3) << PART_WIDTH;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s4.is_div <= op_s3 == OP_DIV;
			p_s4.dz <= dz_s3;
			p_s4.den <= den_s3;
			p_s4.re.big <= num_re >= dlim;
			p_s4.im.big <= num_im >= dlim;
			p_s4.re.neg <= nre_s3;
			p_s4.im.neg <= nim_s3;
			p_s4.re.mag <= mre_s3;
			p_s4.im.mag <= mim_s3;
			p_s4.re.rem <= num_re[REM_W-1:0];
			p_s4.im.rem <= num_im[REM_W-1:0];
			p_s4.re.quo <= '0;
			p_s4.im.quo <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// divider pipeline
	logic  dv [DIV_STAGES+1];
	pipe_t dp [DIV_STAGES+1];

	assign dv[0] = v_s4;
	assign dp[0] = p_s4;

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		cau_div_stage u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (adv),
			.valid_i (dv[g]),
			.data_i  (dp[g]),
			.valid_o (dv[g+1]),
			.data_o  (dp[g+1])
		);
	end

	// output: select, saturate
	pipe_t            fin;
	logic [MAG_W-1:0] fm_re, fm_im;
	part_t            cr, ci;

	always_comb begin
		fin = dp[DIV_STAGES];
		if (fin.dz) begin
			fm_re = '0;
			fm_im = '0;
		end else if (fin.is_div) begin
			fm_re = fin.re.big ? MAG_W'(1) << PART_WIDTH : MAG_W'(fin.re.quo);
			fm_im = fin.im.big ? MAG_W'(1) << PART_WIDTH : MAG_W'(fin.im.quo);
		end else begin
			fm_re = fin.re.mag;
			fm_im = fin.im.mag;
		end
		cr = clamp_part(fin.re.neg, fm_re);
		ci = clamp_part(fin.im.neg, fm_im);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= dv[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data.res_real <= signed'(cr.bits);
			out_data.res_imag <= signed'(ci.bits);
			out_data.div_zero <= fin.dz;
			out_data.overflow <= cr.ovf | ci.ovf;
		end
	end

endmodule

@@ tb/tb_complex_arithmetic_unit.sv @@
`timescale 1ns / 100ps

module tb_complex_arithmetic_unit;
	import cau_pkg::*;

	localparam int LATENCY = 21;
	localparam int N_RANDOM = 1630;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;

	in_t pending_ops[$];
	out_t expected_results[$];
	int errors = 0;
	bit stim_done = 0;
	bit quiet = 0;
	bit hold_send = 0;
	int send_gap = 0;
	int recv_gap = 0;

	complex_arithmetic_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [15:0] sat_part(input longint v, inout bit ovf);
		if (v > 32767) begin
			ovf = 1;
			return 16'sd32767;
		end
		if (v < -32768) begin
			ovf = 1;
			return 16'h8000;
		end
		return v[15:0];
	endfunction

	// quotient truncated toward zero
	function automatic longint trunc_div(input longint num, input longint den);
		longint m;
		m = (num < 0) ? -num : num;
		m = m / den;
		return (num < 0) ? -m : m;
	endfunction

	function automatic out_t complex_result(input in_t x);
		longint ar, ai, br, bi, re, im, den;
		bit ovf;
		out_t r;
		ar = longint'(x.a_real);
		ai = longint'(x.a_imag);
		br = longint'(x.b_real);
		bi = longint'(x.b_imag);
		ovf = 0;
		r = '0;
		case (x.op)
			OP_ADD: begin
				re = ar + br;
				im = ai + bi;
			end
			OP_SUB: begin
				re = ar - br;
				im = ai - bi;
			end
			OP_MUL: begin
				re = trunc_div(ar * br - ai * bi, 256);
				im = trunc_div(ar * bi + ai * br, 256);
			end
			default: begin
				if (br == 0 && bi == 0) begin
					r.div_zero = 1'b1;
					return r;
				end
				den = br * br + bi * bi;
				re = trunc_div((ar * br + ai * bi) * 256, den);
				im = trunc_div((ai * br - ar * bi) * 256, den);
			end
		endcase
		r.res_real = sat_part(re, ovf);
		r.res_imag = sat_part(im, ovf);
		r.overflow = ovf;
		return r;
	endfunction

	function automatic logic [15:0] rand_part();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'($urandom_range(0, 4)) - 16'd2;
			4: return 16'($urandom_range(0, 1023)) - 16'd512;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic push_op(input op_t op, input logic [15:0] ar, input logic [15:0] ai,
			input logic [15:0] br, input logic [15:0] bi);
		in_t x;
		x.op = op;
		x.a_real = ar;
		x.a_imag = ai;
		x.b_real = br;
		x.b_imag = bi;
		pending_ops.push_back(x);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			send_gap <= 0;
		end else if (!in_valid || in_ready) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (!hold_send && pending_ops.size() > 0) begin
				in_valid <= 1'b1;
				in_data <= pending_ops[0];
				expected_results.push_back(complex_result(pending_ops[0]));
				void'(pending_ops.pop_front());
				if (!quiet && $urandom_range(0, 7) == 0)
					send_gap <= $urandom_range(1, 6);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected beat %h", $time, out_data);
					errors++;
				end else begin
					if (out_data.res_real !== expected_results[0].res_real)
						$display("%0t: res_real exp %h got %h", $time,
							expected_results[0].res_real, out_data.res_real);
					if (out_data.res_imag !== expected_results[0].res_imag)
						$display("%0t: res_imag exp %h got %h", $time,
							expected_results[0].res_imag, out_data.res_imag);
					if (out_data.div_zero !== expected_results[0].div_zero)
						$display("%0t: div_zero exp %b got %b", $time,
							expected_results[0].div_zero, out_data.div_zero);
					if (out_data.overflow !== expected_results[0].overflow)
						$display("%0t: overflow exp %b got %b", $time,
							expected_results[0].overflow, out_data.overflow);
					if (out_data !== expected_results[0])
						errors++;
					void'(expected_results.pop_front());
				end
			end
			if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				recv_gap <= $urandom_range(0, 5);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// expectations are queued when a beat is presented, so count the one in flight
	function automatic int outstanding();
		return expected_results.size();
	endfunction

	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed corners
		for (int k = 0; k < 4; k++) begin
			push_op(op_t'(k), 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
			push_op(op_t'(k), 16'h8000, 16'h8000, 16'h8000, 16'h8000);
			push_op(op_t'(k), 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
			push_op(op_t'(k), 16'h0100, 16'hff00, 16'h0080, 16'h0200);
		end
		// division by zero and by one zero part
		push_op(OP_DIV, 16'h1234, 16'h8000, 16'h0000, 16'h0000);
		push_op(OP_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		push_op(OP_DIV, 16'h0300, 16'h0100, 16'h0000, 16'h0001);
		push_op(OP_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000);
		push_op(OP_DIV, 16'hff01, 16'h0005, 16'hfffd, 16'h0000);
		push_op(OP_MUL, 16'hffff, 16'h0001, 16'h0001, 16'h0001);

		// pause until everything drains
		while (pending_ops.size() != 0)
			@(posedge clk);
		hold_send = 1;
		while (outstanding() != 0 || in_valid)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
		hold_send = 0;

		for (int i = 0; i < N_RANDOM; i++) begin
			push_op(op_t'($urandom_range(0, 3)), rand_part(), rand_part(), rand_part(),
				rand_part());
		end
		stim_done = 1;

		// no idling for the last part of the run
		while (pending_ops.size() > 200)
			@(posedge clk);
		quiet = 1;
	end

	initial begin
		while (!(stim_done && pending_ops.size() == 0))
			@(posedge clk);
		while (outstanding() != 0 || in_valid)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
